// File: rtl/pxh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxh_pkg
// Shared sizes, command codes and controller/datapath structs of the pixel
// histogram and min/max unit.
// ----------------------------------------------------------------------------
package pxh_pkg;

  localparam int NUM_BINS        = 1024;
  localparam int COUNT_WIDTH     = 24;
  localparam int PIXEL_FRAC_BITS = 16;

  localparam int CMD_W = 2;
  localparam int PIX_W = PIXEL_FRAC_BITS + 1;
  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = COUNT_WIDTH;
  localparam int PROD_W = PIX_W + IDX_W;

  localparam int IN_TDATA_W  = ((PIX_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * CNT_W + 2 * PIX_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = ((CMD_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [PIX_W-1:0] PIX_ONE   = PIX_W'(1) << PIXEL_FRAC_BITS;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [IDX_W-1:0] BIN_LAST  = IDX_W'(NUM_BINS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the accepted request
    logic clr_start;  // reset extremes and the sweep address
    logic clr_step;   // write one zero and advance the sweep address
    logic rd;         // issue the bin read
    logic upd;        // bin data is back: update or capture it
    logic load;       // move the result into the output register
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             sweep_last;
  } dp_status_t;

endpackage

// File: rtl/pixel_histogram_minmax_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_histogram_minmax_unit
// Histogram of Q1.16 pixels over 1024 saturating bins with running min, max
// and peak bin count.
// ----------------------------------------------------------------------------
// Usage: each request on the s_axis channel carries a command in tuser
// (clear, accumulate, read) and a pixel and bin index in tdata. Every request
// gives exactly one result on the m_axis channel with the bin count (read
// only, else zero), the minimum and maximum pixel and the peak bin count.
// Accumulate and read pass latch, memory read, update and output load before
// the next request is taken; the registered read of the bin memory sets that
// sequence. An unknown command passes only latch and output load. Clear
// sweeps the bin memory one entry a cycle, then loads its result. After
// reset the same sweep runs with s_axis_tready low and produces no result.
// A result waits in the output register while m_axis_tready is low; the next
// request is still taken and processed, and its result waits until the
// register is free.
// ----------------------------------------------------------------------------
module pixel_histogram_minmax_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: pixel_value[16:0], bin_index[26:17], zero pad
  input  logic [pxh_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: command[1:0], zero pad
  input  logic [pxh_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: bin_count[23:0], min_value[40:24], max_value[57:41],
  // max_count[81:58], zero pad
  output logic [pxh_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pxh_pkg::*;

  dp_ctrl_t         ctrl;
  dp_status_t       status;
  logic [CMD_W-1:0] in_cmd;
  logic [CNT_W-1:0] bin_count;
  logic [PIX_W-1:0] min_value;
  logic [PIX_W-1:0] max_value;
  logic [CNT_W-1:0] max_count;

  assign in_cmd = s_axis_tuser[CMD_W-1:0];

  pxh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (in_cmd),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pxh_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .status_o     (status),
    .cmd_i        (in_cmd),
    .pixel_value_i(s_axis_tdata[PIX_W-1:0]),
    .bin_index_i  (s_axis_tdata[PIX_W +: IDX_W]),
    .bin_count_o  (bin_count),
    .min_value_o  (min_value),
    .max_value_o  (max_value),
    .max_count_o  (max_count)
  );

  always_comb begin
    m_axis_tdata                                  = '0;
    m_axis_tdata[CNT_W-1:0]                       = bin_count;
    m_axis_tdata[CNT_W +: PIX_W]                  = min_value;
    m_axis_tdata[CNT_W + PIX_W +: PIX_W]          = max_value;
    m_axis_tdata[CNT_W + 2 * PIX_W +: CNT_W]      = max_count;
  end

endmodule

// File: rtl/pxh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pxh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pxh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxh_datapath
// Bin mapping, bin memory, saturating increment, running extremes, clear
// sweep address and the output register.
// ----------------------------------------------------------------------------
module pxh_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pxh_pkg::dp_ctrl_t         ctrl_i,
  output pxh_pkg::dp_status_t       status_o,
  input  logic [pxh_pkg::CMD_W-1:0] cmd_i,
  input  logic [pxh_pkg::PIX_W-1:0] pixel_value_i,
  input  logic [pxh_pkg::IDX_W-1:0] bin_index_i,
  output logic [pxh_pkg::CNT_W-1:0] bin_count_o,
  output logic [pxh_pkg::PIX_W-1:0] min_value_o,
  output logic [pxh_pkg::PIX_W-1:0] max_value_o,
  output logic [pxh_pkg::CNT_W-1:0] max_count_o
);
  import pxh_pkg::*;

  logic [CMD_W-1:0]  cmd_q;
  logic [PIX_W-1:0]  pix_q;
  logic [IDX_W-1:0]  addr_q;
  logic              idx_ok_q;
  logic [IDX_W-1:0]  sweep_q, sweep_d;
  logic [PIX_W-1:0]  lo_q, lo_d;
  logic [PIX_W-1:0]  hi_q, hi_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [CNT_W-1:0]  res_q;
  logic [CNT_W-1:0]  out_cnt_q, out_peak_q;
  logic [PIX_W-1:0]  out_lo_q, out_hi_q;

  logic [PIX_W-1:0]  pix_sat;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  bin;
  logic [CNT_W-1:0]  rdata;
  logic [CNT_W-1:0]  inc;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CNT_W-1:0]  wdata;

  // Pixels above one land in the last bin.
  assign pix_sat = (pixel_value_i > PIX_ONE) ? PIX_ONE : pixel_value_i;
  assign prod    = PROD_W'(pix_sat) * PROD_W'(NUM_BINS - 1);
  assign bin     = prod[PIXEL_FRAC_BITS +: IDX_W];

  assign inc = (rdata == COUNT_MAX) ? rdata : rdata + CNT_W'(1);

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = inc;
    if (ctrl_i.clr_step) begin
      we    = 1'b1;
      waddr = sweep_q;
      wdata = '0;
    end else if (ctrl_i.upd && cmd_q == CMD_ACCUM) begin
      we = 1'b1;
    end
  end

  pxh_ram #(
    .WIDTH(CNT_W),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    sweep_d = sweep_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    peak_d  = peak_q;
    if (ctrl_i.clr_start) begin
      sweep_d = '0;
      lo_d    = PIX_ONE;
      hi_d    = '0;
      peak_d  = '0;
    end else if (ctrl_i.clr_step) begin
      sweep_d = sweep_q + IDX_W'(1);
    end else if (ctrl_i.upd && cmd_q == CMD_ACCUM) begin
      if (pix_q < lo_q) begin
        lo_d = pix_q;
      end
      if (pix_q > hi_q) begin
        hi_d = pix_q;
      end
      if (inc > peak_q) begin
        peak_d = inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      lo_q    <= PIX_ONE;
      hi_q    <= '0;
      peak_q  <= '0;
    end else begin
      sweep_q <= sweep_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q    <= cmd_i;
      pix_q    <= pix_sat;
      addr_q   <= (cmd_i == CMD_ACCUM) ? bin : bin_index_i;
      idx_ok_q <= (32'(bin_index_i) < NUM_BINS);
      res_q    <= '0;
    end else if (ctrl_i.upd && cmd_q == CMD_READ) begin
      res_q <= idx_ok_q ? rdata : '0;
    end
    if (ctrl_i.load) begin
      out_cnt_q  <= res_q;
      out_lo_q   <= lo_q;
      out_hi_q   <= hi_q;
      out_peak_q <= peak_q;
    end
  end

  assign status_o.cmd        = cmd_q;
  assign status_o.sweep_last = (sweep_q == BIN_LAST);

  assign bin_count_o = out_cnt_q;
  assign min_value_o = out_lo_q;
  assign max_value_o = out_hi_q;
  assign max_count_o = out_peak_q;

endmodule

// File: rtl/pxh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pxh_ctrl
// Sequencer of the histogram unit: clear sweep, bin read and update, and the
// hand-off to the output register.
// ----------------------------------------------------------------------------
module pxh_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [pxh_pkg::CMD_W-1:0] in_cmd_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  input  pxh_pkg::dp_status_t       status_i,
  output pxh_pkg::dp_ctrl_t         ctrl_o
);
  import pxh_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       clr_pend_q, clr_pend_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc;
  logic       out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    clr_pend_d = clr_pend_q;
    ctrl_o     = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d    = clr_pend_q ? S_OUT : S_IDLE;
          clr_pend_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          ctrl_o.latch = 1'b1;
          if (in_cmd_i == CMD_CLEAR) begin
            ctrl_o.clr_start = 1'b1;
            clr_pend_d       = 1'b1;
            state_d          = S_CLEAR;
          end else if (in_cmd_i == CMD_ACCUM || in_cmd_i == CMD_READ) begin
            state_d = S_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_RD: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        ctrl_o.upd = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctrl_o.load = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Reset enters the sweep so the bin memory starts out zeroed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("request accepted but controller stayed idle");

  a_sweep_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && status_i.sweep_last) |=> state_q != S_CLEAR)
    else $error("clear sweep ran past the last bin");

  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_upd_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.upd |-> (status_i.cmd == CMD_ACCUM || status_i.cmd == CMD_READ))
    else $error("bin update for a command that does not use the memory");

endmodule
